// ----- hw/rtl/lhwf_pkg.sv -----
// ----------------------------------------------------------------------------
// lhwf_pkg
// Shared types and codes of the left-hand wall follower: item and result
// words, commands, headings, register indexes and control/status bundles.
// ----------------------------------------------------------------------------
package lhwf_pkg;

	localparam int COORD_W   = 6;
	localparam int POS_LIMIT = 64;

	localparam logic [1:0] CMD_WRITE   = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_STEP    = 2'd2;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_EAST  = 2'd1;
	localparam logic [1:0] DIR_SOUTH = 2'd2;
	localparam logic [1:0] DIR_WEST  = 2'd3;

	localparam logic [1:0] CFG_START_ROW = 2'd0;
	localparam logic [1:0] CFG_START_COL = 2'd1;
	localparam logic [1:0] CFG_EXIT_ROW  = 2'd2;
	localparam logic [1:0] CFG_EXIT_COL  = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic               cell_is_wall;
	} in_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] robot_row;
		logic [COORD_W-1:0] robot_col;
		logic [1:0]         came_from;
		logic               solved;
	} out_word_t;

	typedef struct packed {
		logic wr_cell;
		logic restart;
		logic probe_first;
		logic probe_next;
		logic move;
		logic finish;
		logic step_item;
	} lhwf_ctrl_t;

	typedef struct packed {
		logic open_cell;
		logic last_probe;
		logic done;
	} lhwf_stat_t;

endpackage

// ----- hw/rtl/lhwf_ram.sv -----
// ----------------------------------------------------------------------------
// lhwf_ram
// Generic single-port RAM: one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module lhwf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/lhwf_datapath.sv -----
// ----------------------------------------------------------------------------
// lhwf_datapath
// Robot position, heading, solved flag, configuration registers, wall grid
// memory, neighbour probe stage and result register.
// ----------------------------------------------------------------------------
module lhwf_datapath #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lhwf_pkg::in_word_t  item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data,
	input  lhwf_pkg::lhwf_ctrl_t ctrl,
	output lhwf_pkg::lhwf_stat_t stat,
	output lhwf_pkg::out_word_t result
);

	localparam int ROWS_EFF = (GRID_ROWS < lhwf_pkg::POS_LIMIT) ? GRID_ROWS
		: lhwf_pkg::POS_LIMIT;
	localparam int COLS_EFF = (GRID_COLS < lhwf_pkg::POS_LIMIT) ? GRID_COLS
		: lhwf_pkg::POS_LIMIT;
	localparam int DEPTH    = ROWS_EFF * COLS_EFF;
	localparam int AW       = $clog2(DEPTH);
	localparam int CW       = lhwf_pkg::COORD_W;

	logic [CW-1:0] start_row_q, start_col_q, exit_row_q, exit_col_q;
	logic [CW-1:0] pos_row_q, pos_col_q;
	logic [1:0]    entry_q;
	logic          done_q;

	logic [1:0]    dir_s1;
	logic [1:0]    k_s1;
	logic          inb_s1;
	logic [CW-1:0] nr_s1, nc_s1;

	logic [1:0]    probe_dir;
	logic [CW:0]   pr, pc;
	logic          probe_inb;
	logic [31:0]   probe_lin, wr_lin;
	logic          wr_inb;
	logic [AW-1:0] ram_addr;
	logic          ram_we;
	logic [0:0]    ram_rdata;
	logic          done_next;
	lhwf_pkg::out_word_t result_q;

	always_comb begin
		probe_dir = ctrl.probe_first ? entry_q + 2'd1 : dir_s1 + 2'd1;
		pr = {1'b0, pos_row_q};
		pc = {1'b0, pos_col_q};
		case (probe_dir)
			lhwf_pkg::DIR_NORTH: pr = pr - 7'd1;
			lhwf_pkg::DIR_EAST:  pc = pc + 7'd1;
			lhwf_pkg::DIR_SOUTH: pr = pr + 7'd1;
			default:             pc = pc - 7'd1;
		endcase
	end

	assign probe_inb = (pr < 7'(ROWS_EFF)) && (pc < 7'(COLS_EFF));
	assign probe_lin = 32'(pr[CW-1:0]) * 32'(COLS_EFF) + 32'(pc[CW-1:0]);
	assign wr_inb    = ({1'b0, item.cell_row} < 7'(ROWS_EFF))
		&& ({1'b0, item.cell_col} < 7'(COLS_EFF));
	assign wr_lin    = 32'(item.cell_row) * 32'(COLS_EFF) + 32'(item.cell_col);
	assign ram_we    = ctrl.wr_cell && wr_inb;
	assign ram_addr  = ctrl.wr_cell ? wr_lin[AW-1:0] : probe_lin[AW-1:0];

	lhwf_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(item.cell_is_wall),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctrl.probe_first || ctrl.probe_next) begin
			dir_s1 <= probe_dir;
			k_s1   <= ctrl.probe_first ? 2'd0 : k_s1 + 2'd1;
			inb_s1 <= probe_inb;
			nr_s1  <= pr[CW-1:0];
			nc_s1  <= pc[CW-1:0];
		end
	end

	assign done_next = done_q || (ctrl.step_item && (pos_row_q == exit_row_q)
		&& (pos_col_q == exit_col_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= '0;
			start_col_q <= '0;
			exit_row_q  <= '0;
			exit_col_q  <= '0;
			pos_row_q   <= '0;
			pos_col_q   <= '0;
			entry_q     <= lhwf_pkg::DIR_SOUTH;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lhwf_pkg::CFG_START_ROW: start_row_q <= cfg_data;
					lhwf_pkg::CFG_START_COL: start_col_q <= cfg_data;
					lhwf_pkg::CFG_EXIT_ROW:  exit_row_q  <= cfg_data;
					lhwf_pkg::CFG_EXIT_COL:  exit_col_q  <= cfg_data;
					default: ;
				endcase
			end
			if (ctrl.restart) begin
				pos_row_q <= start_row_q;
				pos_col_q <= start_col_q;
				entry_q   <= lhwf_pkg::DIR_SOUTH;
				done_q    <= 1'b0;
			end else if (ctrl.move) begin
				pos_row_q <= nr_s1;
				pos_col_q <= nc_s1;
				entry_q   <= dir_s1 + 2'd2;
			end else if (ctrl.finish) begin
				done_q <= done_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			result_q.robot_row <= pos_row_q;
			result_q.robot_col <= pos_col_q;
			result_q.came_from <= entry_q;
			result_q.solved    <= done_next;
		end
	end

	assign stat.open_cell  = inb_s1 && !ram_rdata[0];
	assign stat.last_probe = (k_s1 == 2'd3);
	assign stat.done       = done_q;
	assign result          = result_q;

endmodule

// ----- hw/rtl/lhwf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhwf_ctrl
// Sequencer: takes one word, walks the left/straight/right/back probes of a
// step one per cycle, then loads the result register when it is free.
// ----------------------------------------------------------------------------
module lhwf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           command,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  lhwf_pkg::lhwf_stat_t stat,
	output lhwf_pkg::lhwf_ctrl_t ctrl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       step_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || !result_stall;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		ctrl.step_item = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FIN;
					unique case (command)
						lhwf_pkg::CMD_WRITE:   ctrl.wr_cell = 1'b1;
						lhwf_pkg::CMD_RESTART: ctrl.restart = 1'b1;
						lhwf_pkg::CMD_STEP: begin
							if (!stat.done) begin
								ctrl.probe_first = 1'b1;
								state_d          = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (stat.open_cell) begin
					ctrl.move = 1'b1;
					state_d   = ST_FIN;
				end else if (stat.last_probe) begin
					state_d = ST_FIN;
				end else begin
					ctrl.probe_next = 1'b1;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= (command == lhwf_pkg::CMD_STEP);
			end
			if (ctrl.finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_probe_past_back: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.probe_next |-> !stat.last_probe)
		else $error("probe issued past the turn-back side");
	a_move_then_fin: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.move |=> state_q == ST_FIN)
		else $error("move not followed by result load");
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.finish |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished word not presented");
	a_scan_has_probe: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> $past(ctrl.probe_first || ctrl.probe_next))
		else $error("scan without a pending probe");
`endif

endmodule

// ----- hw/rtl/left_hand_wall_follower.sv -----
// ----------------------------------------------------------------------------
// left_hand_wall_follower
// Left-hand wall-following maze walker over a wall grid held in a
// single-port memory.
// ----------------------------------------------------------------------------
// A grid write, a restart or an unused command: the word is taken, then the
// result register is loaded. A step: the word is taken, the neighbours are
// probed in turn on the single-port grid memory (left, straight, right,
// back; up to four) until one is open, then the result is loaded; a step
// after solved skips the probes. The next word is taken while a result still
// waits. Only the first 64 rows and columns of the grid are reachable; cells
// outside the grid read as walls, and writes there drop.
module left_hand_wall_follower #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lhwf_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output lhwf_pkg::out_word_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data
);

	lhwf_pkg::lhwf_ctrl_t ctrl;
	lhwf_pkg::lhwf_stat_t stat;

	lhwf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.command     (item.command),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stat        (stat),
		.ctrl        (ctrl)
	);

	lhwf_datapath #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.result   (result)
	);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the left-hand wall follower. A short table of
// directed words (corner cells, a boxed-in start, solve and hold, restart
// after solve) runs first; then small random mazes are built, walked from
// configured start cells and checked word by word against a local model of
// the walker, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         WORD_GOAL  = 1100;
	localparam int         WALK_LIMIT = 40;

	localparam lhwf_pkg::out_word_t AT_HOME   = '{6'd0, 6'd0, lhwf_pkg::DIR_SOUTH, 1'b0};
	localparam lhwf_pkg::out_word_t HOME_DONE = '{6'd0, 6'd0, lhwf_pkg::DIR_SOUTH, 1'b1};
	localparam lhwf_pkg::out_word_t AT_CORNER = '{6'd63, 6'd63, lhwf_pkg::DIR_SOUTH, 1'b0};

	typedef struct packed {
		logic                is_reg;
		logic [1:0]          reg_idx;
		logic [5:0]          reg_val;
		lhwf_pkg::in_word_t  word;
		logic                typed;
		lhwf_pkg::out_word_t report;
	} plan_row_t;

	plan_row_t directed_plan [24] = '{
		'{1'b0, 2'd0, 6'd0, '{CMD_UNUSED, 6'd63, 6'd63, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{CMD_UNUSED, 6'd0, 6'd0, 1'b0}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd0, 6'd1, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd1, 6'd0, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd5, 6'd42, 1'b1}, 1'b1, HOME_DONE},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd0, 6'd0, 1'b0}, 1'b1, HOME_DONE},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_RESTART, 6'd63, 6'd63, 1'b1}, 1'b1, AT_HOME},
		'{1'b1, lhwf_pkg::CFG_START_ROW, 6'd63, '0, 1'b0, '0},
		'{1'b1, lhwf_pkg::CFG_START_COL, 6'd63, '0, 1'b0, '0},
		'{1'b1, lhwf_pkg::CFG_EXIT_ROW, 6'd62, '0, 1'b0, '0},
		'{1'b1, lhwf_pkg::CFG_EXIT_COL, 6'd62, '0, 1'b0, '0},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd63, 6'd62, 1'b0}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd62, 6'd63, 1'b0}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd62, 6'd62, 1'b0}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd61, 6'd63, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd63, 6'd61, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd61, 6'd62, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_WRITE, 6'd62, 6'd61, 1'b1}, 1'b1, AT_HOME},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_RESTART, 6'd0, 6'd0, 1'b0}, 1'b1, AT_CORNER},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd63, 6'd0, 1'b1}, 1'b0, '0},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd0, 6'd63, 1'b0}, 1'b0, '0},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd21, 6'd42, 1'b1}, 1'b0, '0},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_RESTART, 6'd42, 6'd21, 1'b0}, 1'b1, AT_CORNER},
		'{1'b0, 2'd0, 6'd0, '{lhwf_pkg::CMD_STEP, 6'd7, 6'd56, 1'b0}, 1'b0, '0}
	};

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	lhwf_pkg::in_word_t  item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	lhwf_pkg::out_word_t result;
	logic                cfg_we       = 1'b0;
	logic [1:0]          cfg_index    = '0;
	logic [5:0]          cfg_data     = '0;

	bit grid_wall  [lhwf_pkg::POS_LIMIT][lhwf_pkg::POS_LIMIT];
	bit grid_known [lhwf_pkg::POS_LIMIT][lhwf_pkg::POS_LIMIT];
	logic [5:0] reg_start_row = '0;
	logic [5:0] reg_start_col = '0;
	logic [5:0] reg_exit_row  = '0;
	logic [5:0] reg_exit_col  = '0;
	logic [5:0] bot_row       = '0;
	logic [5:0] bot_col       = '0;
	logic [1:0] bot_from      = lhwf_pkg::DIR_SOUTH;
	logic       bot_solved    = 1'b0;

	lhwf_pkg::out_word_t robot_reports [$];

	int send_gap_pct   = 0;
	int stall_pct      = 0;
	int mismatch_count = 0;
	int words_sent     = 0;
	int steps_taken    = 0;
	int exits_reached  = 0;
	int boxed_in       = 0;
	int mazes_built    = 0;

	left_hand_wall_follower i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic bit neighbour_of(input logic [1:0] dir, output int nr, output int nc);
		nr = int'(bot_row);
		nc = int'(bot_col);
		case (dir)
			lhwf_pkg::DIR_NORTH: nr = nr - 1;
			lhwf_pkg::DIR_EAST:  nc = nc + 1;
			lhwf_pkg::DIR_SOUTH: nr = nr + 1;
			default:             nc = nc - 1;
		endcase
		return nr >= 0 && nc >= 0 && nr < lhwf_pkg::POS_LIMIT && nc < lhwf_pkg::POS_LIMIT;
	endfunction

	// left, straight, right, back relative to the side the robot came from
	function automatic lhwf_pkg::out_word_t advance_robot(input lhwf_pkg::in_word_t w);
		int k, nr, nc;
		logic [1:0] dir;
		bit moved;
		moved = 1'b0;
		case (w.command)
			lhwf_pkg::CMD_WRITE: begin
				grid_wall[w.cell_row][w.cell_col] = w.cell_is_wall;
				grid_known[w.cell_row][w.cell_col] = 1'b1;
			end
			lhwf_pkg::CMD_RESTART: begin
				bot_row = reg_start_row;
				bot_col = reg_start_col;
				bot_from = lhwf_pkg::DIR_SOUTH;
				bot_solved = 1'b0;
			end
			lhwf_pkg::CMD_STEP: if (!bot_solved) begin
				for (k = 1; k <= 4; k++) begin
					dir = bot_from + 2'(k);
					if (!moved && neighbour_of(dir, nr, nc) && !grid_wall[nr][nc]) begin
						bot_row = 6'(nr);
						bot_col = 6'(nc);
						bot_from = dir + 2'd2;
						moved = 1'b1;
					end
				end
				if (!moved)
					boxed_in++;
				if (bot_row == reg_exit_row && bot_col == reg_exit_col) begin
					bot_solved = 1'b1;
					exits_reached++;
				end
			end
			default: ;
		endcase
		return '{bot_row, bot_col, bot_from, bot_solved};
	endfunction

	function automatic lhwf_pkg::in_word_t cell_word(input int r, input int c, input bit wall);
		lhwf_pkg::in_word_t w;
		w.command = lhwf_pkg::CMD_WRITE;
		w.cell_row = 6'(r);
		w.cell_col = 6'(c);
		w.cell_is_wall = wall;
		return w;
	endfunction

	function automatic lhwf_pkg::in_word_t random_word(input logic [1:0] cmd);
		lhwf_pkg::in_word_t w;
		w.command = cmd;
		w.cell_row = 6'($urandom_range(63));
		w.cell_col = 6'($urandom_range(63));
		w.cell_is_wall = 1'($urandom_range(1));
		return w;
	endfunction

	function automatic int pick_in(input int lo, input int span);
		case ($urandom_range(2))
			0: return lo;
			1: return lo + span - 1;
			default: return lo + int'($urandom_range(span - 1));
		endcase
	endfunction

	task automatic send_word(input lhwf_pkg::in_word_t w, input bit typed = 1'b0,
			input lhwf_pkg::out_word_t report = '0);
		lhwf_pkg::out_word_t walked;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			item <= random_word(2'($urandom_range(3)));
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		walked = advance_robot(w);
		robot_reports = {robot_reports, typed ? report : walked};
		if (w.command != CMD_UNUSED)
			words_sent++;
		if (w.command == lhwf_pkg::CMD_STEP)
			steps_taken++;
	endtask

	// a word is always outstanding right after acceptance, so valid drops here
	task automatic drain_reports();
		if (robot_reports.size() != 0) begin
			item_valid <= 1'b0;
			while (robot_reports.size() != 0)
				@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
		drain_reports();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			lhwf_pkg::CFG_START_ROW: reg_start_row = val;
			lhwf_pkg::CFG_START_COL: reg_start_col = val;
			lhwf_pkg::CFG_EXIT_ROW:  reg_exit_row = val;
			default:                 reg_exit_col = val;
		endcase
	endtask

	// write any unwritten neighbour before the walker may probe it
	task automatic fill_around();
		int d, nr, nc;
		for (d = 0; d < 4; d++)
			if (neighbour_of(2'(d), nr, nc) && !grid_known[nr][nc])
				send_word(cell_word(nr, nc, $urandom_range(99) < 35));
	endtask

	always @(posedge clk) begin
		lhwf_pkg::out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (robot_reports.size() == 0) begin
				$error("result word with nothing outstanding: %p", result);
				mismatch_count++;
			end else begin
				want = robot_reports.pop_front();
				if (want.robot_row !== result.robot_row) begin
					$error("robot_row: expected %0d, got %0d", want.robot_row, result.robot_row);
					mismatch_count++;
				end
				if (want.robot_col !== result.robot_col) begin
					$error("robot_col: expected %0d, got %0d", want.robot_col, result.robot_col);
					mismatch_count++;
				end
				if (want.came_from !== result.came_from) begin
					$error("came_from: expected %0d, got %0d", want.came_from, result.came_from);
					mismatch_count++;
				end
				if (want.solved !== result.solved) begin
					$error("solved: expected %0d, got %0d", want.solved, result.solved);
					mismatch_count++;
				end
			end
		end
		result_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	initial begin
		int h, wd, r0, c0, sr, sc, er, ec, r, c, steps, extra, roll, episode;
		bit wall;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_reg)
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			else
				send_word(directed_plan[i].word, directed_plan[i].typed,
					directed_plan[i].report);
		end

		episode = 0;
		while (words_sent < WORD_GOAL) begin
			case (episode % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 59;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 59;
				end
				default: begin
					send_gap_pct = 33;
					stall_pct = 33;
				end
			endcase

			h = $urandom_range(6, 3);
			wd = $urandom_range(6, 3);
			if (episode % 2 == 0) begin
				r0 = $urandom_range(1) ? 0 : lhwf_pkg::POS_LIMIT - h;
				c0 = $urandom_range(1) ? 0 : lhwf_pkg::POS_LIMIT - wd;
			end else begin
				r0 = $urandom_range(lhwf_pkg::POS_LIMIT - h);
				c0 = $urandom_range(lhwf_pkg::POS_LIMIT - wd);
			end
			sr = pick_in(r0, h);
			sc = pick_in(c0, wd);
			er = pick_in(r0, h);
			ec = pick_in(c0, wd);
			write_reg(lhwf_pkg::CFG_START_ROW, 6'(sr));
			write_reg(lhwf_pkg::CFG_START_COL, 6'(sc));
			write_reg(lhwf_pkg::CFG_EXIT_ROW, 6'(er));
			write_reg(lhwf_pkg::CFG_EXIT_COL, 6'(ec));

			// wall ring around the box, random interior, start and exit open
			for (r = r0 - 1; r <= r0 + h; r++)
				for (c = c0 - 1; c <= c0 + wd; c++)
					if (r >= 0 && c >= 0 && r < lhwf_pkg::POS_LIMIT
							&& c < lhwf_pkg::POS_LIMIT) begin
						wall = (r < r0 || r >= r0 + h || c < c0 || c >= c0 + wd)
							|| ($urandom_range(99) < 35);
						if ((r == sr && c == sc) || (r == er && c == ec))
							wall = 1'b0;
						send_word(cell_word(r, c, wall));
					end
			mazes_built++;

			send_word(random_word(lhwf_pkg::CMD_RESTART));
			steps = 0;
			extra = 0;
			while (steps < WALK_LIMIT && extra < 2) begin
				roll = $urandom_range(99);
				if (roll < 4)
					send_word(random_word(lhwf_pkg::CMD_RESTART));
				else if (roll < 7)
					send_word(random_word(CMD_UNUSED));
				else if (roll < 11)
					send_word(random_word(lhwf_pkg::CMD_WRITE));
				else if (roll < 14)
					drain_reports();
				fill_around();
				send_word(random_word(lhwf_pkg::CMD_STEP));
				steps++;
				if (bot_solved)
					extra++;
			end
			episode++;
		end

		drain_reports();
		repeat (20) @(posedge clk);
		$display("summary: %0d words over %0d random mazes, %0d walk steps",
			words_sent, mazes_built, steps_taken);
		$display("summary: %0d exits reached, %0d steps boxed in on all sides",
			exits_reached, boxed_in);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
